>>> rtl/assert_macros.svh
// assertion macros shared by the sobel edge magnitude rtl
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SOBEL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SOBEL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SOBEL_ASSERT(label, clk, rst_n, prop, msg)

`define SOBEL_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/sobel_pkg.sv
// shared types and constants for the sobel edge magnitude core
// no dependencies
package sobel_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIX_W        = 8;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam int MIN_DIM      = 3;

	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	localparam int SUM_W   = 10;
	localparam int PROD_W  = 18;
	localparam int SHIFT   = 7;
	localparam logic [PROD_W-1:0] COEF_BIG   = 18'd123;
	localparam logic [PROD_W-1:0] COEF_SMALL = 18'd51;
	localparam logic [PROD_W-SHIFT-1:0] MAG_MAX = 11'd255;

	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] newer;
	} line_pair_t;

	// win[column][row], column 0 oldest, row 0 top
	typedef struct packed {
		logic [2:0][2:0][PIX_W-1:0] win;
		logic                       row_end;
		logic                       frame_end;
	} sobel_item_t;

endpackage

>>> rtl/sobel_edge_magnitude_core.sv
// top level of the sobel 3x3 edge magnitude core
// depends on sobel_pkg, sobel_front, sobel_queue, sobel_back
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata = pixel
//   m_*      out  m_tvalid/m_tready    m_tdata = magnitude, m_tlast = row_end, m_tuser = frame_end
//   cfg_*    in   cfg_we               cfg_index selects width or height, cfg_data value
//
// one pixel per clock sustained while m_tready stays high
// a result is offered on m_* after its pixel passes the intake, queue, gradient and output registers
// the line store takes one read at intake and one write-back the next cycle, at different columns
// s_tready drops while the queue and the intake stage hold four beats between them
// reset clears counters, window and pipeline valids; the line store is not cleared
module sobel_edge_magnitude_core #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sobel_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sobel_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sobel_pkg::PIX_W-1:0]         m_tdata,   // [7:0] magnitude
	output logic                                m_tlast,
	output logic                                m_tuser    // [0] frame_end
);

	logic                             push, pop, q_valid;
	sobel_pkg::sobel_item_t           push_item, head_item;
	logic [sobel_pkg::LEVEL_W-1:0]    level;

	sobel_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.level     (level)
	);

	sobel_queue #(
		.DEPTH (sobel_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.not_empty (q_valid),
		.head_item (head_item),
		.level     (level)
	);

	sobel_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (head_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/sobel_queue.sv
// short queue of interior windows between front and back
// depends on sobel_pkg and assert_macros.svh
module sobel_queue #(
	parameter int DEPTH = sobel_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  sobel_pkg::sobel_item_t        push_item,
	input  logic                          pop,
	output logic                          not_empty,
	output sobel_pkg::sobel_item_t        head_item,
	output logic [$clog2(DEPTH+1)-1:0]    level
);

	`include "assert_macros.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	sobel_pkg::sobel_item_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [LW-1:0] level_q;
	logic          do_push, do_pop;

	assign do_push   = push;
	assign do_pop    = pop && (level_q != '0);
	assign not_empty = (level_q != '0);
	assign head_item = entry_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	`SOBEL_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && !pop && (level_q == LW'(DEPTH)), "queue overflow")
	`SOBEL_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && (level_q == '0), "pop from empty queue")

endmodule

>>> rtl/sobel_front.sv
// front end: config registers, pixel intake, raster counters, line store and 3x3 window
// depends on sobel_pkg and assert_macros.svh
module sobel_front #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sobel_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sobel_pkg::PIX_W-1:0]         s_tdata,
	output logic                                push,
	output sobel_pkg::sobel_item_t              push_item,
	input  logic [sobel_pkg::LEVEL_W-1:0]       level
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = (sobel_pkg::CFG_WIDTH_W > CW + 1) ? sobel_pkg::CFG_WIDTH_W : CW + 1;
	localparam int HW = (sobel_pkg::CFG_HEIGHT_W > RW + 1) ? sobel_pkg::CFG_HEIGHT_W : RW + 1;
	localparam int LW = sobel_pkg::LEVEL_W;

	logic [sobel_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [sobel_pkg::CFG_HEIGHT_W-1:0] height_q;
	logic [WW-1:0] width_ext, width_cl;
	logic [HW-1:0] height_ext, height_cl;
	logic [CW-1:0] last_col_idx;
	logic [RW-1:0] last_row_idx;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept, last_col, last_row;

	sobel_pkg::line_pair_t line_mem [MAX_WIDTH];
	sobel_pkg::line_pair_t line_s1;
	logic [sobel_pkg::PIX_W-1:0] pix_s1;
	logic [CW-1:0] col_s1;
	logic          valid_s1, interior_s1, row_end_s1, frame_end_s1;

	logic [2:0][2:0][sobel_pkg::PIX_W-1:0] win_q, win_next;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RST;
			height_q <= sobel_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (sobel_pkg::cfg_reg_t'(cfg_index))
				sobel_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[sobel_pkg::CFG_WIDTH_W-1:0];
				sobel_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[sobel_pkg::CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_ext  = WW'(width_q);
		height_ext = HW'(height_q);
		if (width_ext < WW'(sobel_pkg::MIN_DIM)) begin
			width_cl = WW'(sobel_pkg::MIN_DIM);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			width_cl = WW'(MAX_WIDTH);
		end else begin
			width_cl = width_ext;
		end
		if (height_ext < HW'(sobel_pkg::MIN_DIM)) begin
			height_cl = HW'(sobel_pkg::MIN_DIM);
		end else if (height_ext > HW'(MAX_HEIGHT)) begin
			height_cl = HW'(MAX_HEIGHT);
		end else begin
			height_cl = height_ext;
		end
		last_col_idx = CW'(width_cl - 1'b1);
		last_row_idx = RW'(height_cl - 1'b1);
	end

	assign last_col = (col_q >= last_col_idx);
	assign last_row = (row_q >= last_row_idx);

	// room for the beat in s1 and the one taken now
	assign s_tready = ((LW + 1)'(level) + (LW + 1)'(valid_s1)) < (LW + 1)'(sobel_pkg::QUEUE_DEPTH);
	assign accept   = s_tvalid && s_tready;

	// line store: read at intake, written back in the following cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1] <= '{older: line_s1.newer, newer: pix_s1};
		end
		if (accept) begin
			line_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= s_tdata;
			col_s1       <= col_q;
			interior_s1  <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	always_comb begin
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = {pix_s1, line_s1.newer, line_s1.older};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			win_q    <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				win_q <= win_next;
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign push                = valid_s1 && interior_s1;
	assign push_item.win       = win_next;
	assign push_item.row_end   = row_end_s1;
	assign push_item.frame_end = frame_end_s1;

	`SOBEL_ASSERT(a_stall_has_cause, clk, arst_n, !s_tready |-> (level != '0) || valid_s1, "intake stalled with nothing in flight")
	`SOBEL_ASSERT(a_col_in_range, clk, arst_n, col_q <= CW'(MAX_WIDTH - 1), "column beyond line store")

endmodule

>>> rtl/sobel_back.sv
// back end: gradients, magnitude approximation, saturation and output register
// depends on sobel_pkg and assert_macros.svh
module sobel_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  sobel_pkg::sobel_item_t        q_item,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sobel_pkg::PIX_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	`include "assert_macros.svh"

	localparam int SW = sobel_pkg::SUM_W;
	localparam int PW = sobel_pkg::PROD_W;
	localparam int MW = sobel_pkg::PROD_W - sobel_pkg::SHIFT;

	logic [SW-1:0] gx_pos, gx_neg, gy_pos, gy_neg, ax, ay;
	logic [SW-1:0] big_s1, small_s1;
	logic          valid_s1, row_end_s1, frame_end_s1;
	logic [PW-1:0] mix;
	logic [MW-1:0] mag_raw;
	logic          out_free, s1_free;

	logic                        valid_q, tlast_q, tuser_q;
	logic [sobel_pkg::PIX_W-1:0] mag_q;

	// right column minus left column, bottom row minus top row
	always_comb begin
		gx_pos = SW'(q_item.win[2][0]) + SW'({q_item.win[2][1], 1'b0}) + SW'(q_item.win[2][2]);
		gx_neg = SW'(q_item.win[0][0]) + SW'({q_item.win[0][1], 1'b0}) + SW'(q_item.win[0][2]);
		gy_pos = SW'(q_item.win[0][2]) + SW'({q_item.win[1][2], 1'b0}) + SW'(q_item.win[2][2]);
		gy_neg = SW'(q_item.win[0][0]) + SW'({q_item.win[1][0], 1'b0}) + SW'(q_item.win[2][0]);
		ax = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
		ay = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
	end

	assign out_free = !valid_q || m_tready;
	assign s1_free  = !valid_s1 || out_free;
	assign pop      = q_valid && s1_free;

	always_ff @(posedge clk) begin
		if (pop) begin
			big_s1       <= (ax > ay) ? ax : ay;
			small_s1     <= (ax > ay) ? ay : ax;
			row_end_s1   <= q_item.row_end;
			frame_end_s1 <= q_item.frame_end;
		end
	end

	assign mix     = PW'(big_s1) * sobel_pkg::COEF_BIG + PW'(small_s1) * sobel_pkg::COEF_SMALL;
	assign mag_raw = mix[PW-1:sobel_pkg::SHIFT];

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			mag_q   <= (mag_raw > sobel_pkg::MAG_MAX) ? sobel_pkg::MAG_MAX[sobel_pkg::PIX_W-1:0]
			                                          : mag_raw[sobel_pkg::PIX_W-1:0];
			tlast_q <= row_end_s1;
			tuser_q <= frame_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= q_valid;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = mag_q;
	assign m_tlast  = tlast_q;
	assign m_tuser  = tuser_q;

	`SOBEL_ASSERT(a_frame_end_on_row_end, clk, arst_n, valid_q && tuser_q |-> tlast_q, "frame end without row end")
	`SOBEL_ASSERT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !out_free |=> valid_s1 && $stable(big_s1), "stage one lost under stall")

endmodule

>>> verif/sobel_edge_magnitude_core_test.sv
// self-checking testbench for sobel_edge_magnitude_core: raster pixel beats in, edge
// magnitude beats out, predicted per pixel and compared field by field in arrival order
// depends on sobel_pkg and the rtl of sobel_edge_magnitude_core
module sobel_edge_magnitude_core_test;

	typedef struct {
		logic [sobel_pkg::PIX_W-1:0] magnitude;
		logic                        row_end;
		logic                        frame_end;
	} edge_result_t;

	typedef enum int {
		STYLE_NOISE,
		STYLE_BINARY,
		STYLE_SMOOTH,
		STYLE_FLAT
	} pixel_style_t;

	localparam int LINE_DEPTH = sobel_pkg::MAX_WIDTH_DEF;
	localparam int DRAIN_CYCLES = 8;

	// raster order, three rows of three
	localparam logic [0:3][0:8][sobel_pkg::PIX_W-1:0] EDGE_PATTERNS = '{
		'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255},
		'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd20},
		'{8'd10, 8'd10, 8'd10, 8'd20, 8'd20, 8'd20, 8'd40, 8'd40, 8'd40}
	};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [sobel_pkg::PIX_W-1:0]       s_tdata = '0;   // [7:0] pixel
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [sobel_pkg::PIX_W-1:0]       m_tdata;        // [7:0] magnitude
	logic                              m_tlast;
	logic                              m_tuser;        // [0] frame_end

	int src_idle_pct = 26;
	int sink_idle_pct = 85;
	int mismatches = 0;

	// predictor state
	logic [sobel_pkg::CFG_WIDTH_W-1:0]  width_reg = sobel_pkg::WIDTH_RST;
	logic [sobel_pkg::CFG_HEIGHT_W-1:0] height_reg = sobel_pkg::HEIGHT_RST;
	bit [sobel_pkg::PIX_W-1:0]          line_two_up [LINE_DEPTH];
	bit [sobel_pkg::PIX_W-1:0]          line_one_up [LINE_DEPTH];
	bit                                 two_up_set [LINE_DEPTH];
	bit                                 one_up_set [LINE_DEPTH];
	int                                 nbhd [3][3];
	int unsigned                        next_col = 0;
	int unsigned                        next_row = 0;
	edge_result_t                       pending_edges [$];

	sobel_edge_magnitude_core DUT (.*);

	always #1 clk = ~clk;

	always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

	always @(posedge clk) begin
		edge_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: magnitude %0d row_end %b frame_end %b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = pending_edges.pop_front();
				if (m_tdata !== want.magnitude || m_tlast !== want.row_end ||
						m_tuser !== want.frame_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%b/%b, got %0d/%b/%b",
							want.magnitude, want.row_end, want.frame_end,
							m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < sobel_pkg::MIN_DIM)
			return sobel_pkg::MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int unsigned frame_cols();
		return clamp_dim(32'(width_reg), sobel_pkg::MAX_WIDTH_DEF);
	endfunction

	function automatic int unsigned frame_rows();
		return clamp_dim(32'(height_reg), sobel_pkg::MAX_HEIGHT_DEF);
	endfunction

	function automatic int unsigned pixels_left();
		int unsigned n;
		n = (next_col >= frame_cols() - 1) ? 1 : frame_cols() - next_col;
		if (next_row < frame_rows() - 1)
			n += (frame_rows() - 1 - next_row) * frame_cols();
		return n;
	endfunction

	// widest row whose line store columns all hold real pixels
	function automatic int unsigned settled_width();
		int unsigned n = 0;
		while (n < LINE_DEPTH && two_up_set[n] && one_up_set[n])
			n++;
		return n;
	endfunction

	function automatic void predict_pixel(logic [sobel_pkg::PIX_W-1:0] pix);
		int unsigned c;
		int gx, gy, ax, ay, big_g, small_g, mag;
		logic last_col, last_row;
		edge_result_t res;
		c = next_col;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 2; k++)
				nbhd[r][k] = nbhd[r][k + 1];
		nbhd[0][2] = int'(line_two_up[c]);
		nbhd[1][2] = int'(line_one_up[c]);
		nbhd[2][2] = int'(pix);
		line_two_up[c] = line_one_up[c];
		two_up_set[c] = one_up_set[c];
		line_one_up[c] = pix;
		one_up_set[c] = 1'b1;

		last_col = (c >= frame_cols() - 1);
		last_row = (next_row >= frame_rows() - 1);

		if (next_row >= 2 && c >= 2) begin
			gx = nbhd[0][2] - nbhd[0][0] + 2 * (nbhd[1][2] - nbhd[1][0]) + nbhd[2][2] - nbhd[2][0];
			gy = nbhd[2][0] + 2 * nbhd[2][1] + nbhd[2][2] - nbhd[0][0] - 2 * nbhd[0][1] - nbhd[0][2];
			ax = (gx < 0) ? -gx : gx;
			ay = (gy < 0) ? -gy : gy;
			big_g = (ax > ay) ? ax : ay;
			small_g = (ax > ay) ? ay : ax;
			mag = (big_g * int'(sobel_pkg::COEF_BIG) + small_g * int'(sobel_pkg::COEF_SMALL))
				>> sobel_pkg::SHIFT;
			if (mag > int'(sobel_pkg::MAG_MAX))
				mag = int'(sobel_pkg::MAG_MAX);
			res.magnitude = mag[sobel_pkg::PIX_W-1:0];
			res.row_end = last_col;
			res.frame_end = last_col && last_row;
			pending_edges.push_back(res);
		end

		if (last_col) begin
			next_col = 0;
			next_row = last_row ? 0 : next_row + 1;
		end else begin
			next_col = c + 1;
		end
	endfunction

	task automatic send_pixel(logic [sobel_pkg::PIX_W-1:0] pix);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= (sobel_pkg::PIX_W)'($urandom_range(0, 255));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		predict_pixel(pix);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(sobel_pkg::cfg_reg_t idx, int unsigned value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (sobel_pkg::CFG_DATA_W)'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == sobel_pkg::REG_IMAGE_WIDTH)
			width_reg = (sobel_pkg::CFG_WIDTH_W)'(value);
		else
			height_reg = (sobel_pkg::CFG_HEIGHT_W)'(value);
	endtask

	function automatic logic [sobel_pkg::PIX_W-1:0] shade(pixel_style_t style, int base);
		int v;
		case (style)
			STYLE_BINARY: v = $urandom_range(0, 1) * 255;
			STYLE_SMOOTH: v = base + int'($urandom_range(0, 16)) - 8;
			STYLE_FLAT: v = base;
			default: v = $urandom_range(0, 255);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[sobel_pkg::PIX_W-1:0];
	endfunction

	task automatic send_run(int unsigned n, pixel_style_t style);
		int base;
		base = $urandom_range(0, 255);
		repeat (n) send_pixel(shade(style, base));
	endtask

	function automatic int unsigned width_choice();
		int unsigned v;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			v = $urandom_range(0, 2);
		else if (pick == 1)
			v = $urandom_range(13, 40);
		else
			v = $urandom_range(3, 12);
		// bits above the width field are dropped by the block
		v += $urandom_range(0, 3) << sobel_pkg::CFG_WIDTH_W;
		return v;
	endfunction

	// one full row at the reset width, then a narrower width ends the next row and frame
	task automatic test_reset_geometry();
		send_run(32'(sobel_pkg::WIDTH_RST) + 3, STYLE_NOISE);
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 5);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 3);
		send_run(pixels_left(), STYLE_NOISE);
	endtask

	task automatic test_pattern_frames();
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 'h1803);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 3);
		for (int f = 0; f < 4; f++)
			for (int i = 0; i < 9; i++)
				send_pixel(EDGE_PATTERNS[f][i]);
	endtask

	task automatic test_dimension_clamps();
		for (int d = 0; d < 3; d++) begin
			write_reg(sobel_pkg::REG_IMAGE_WIDTH, d);
			write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 2 - d);
			send_run(9, STYLE_NOISE);
		end
	endtask

	task automatic test_mid_frame_changes();
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 6);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 6);
		send_run(2 * 6 + 4, STYLE_NOISE);
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 3);
		send_run(1 + 3, STYLE_NOISE);
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 6);
		send_run(3, STYLE_NOISE);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 0);
		send_run(pixels_left(), STYLE_NOISE);
	endtask

	task automatic test_random_frames(int unsigned quota);
		int unsigned sent, n, cap;
		pixel_style_t style;
		sent = 0;
		while (sent < quota) begin
			style = pixel_style_t'($urandom_range(0, 3));
			if (next_col == 0 && next_row == 0 && $urandom_range(0, 2) == 0) begin
				write_reg(sobel_pkg::REG_IMAGE_WIDTH, width_choice());
				write_reg(sobel_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 9));
			end
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, pixels_left());
			else
				n = pixels_left();
			send_run(n, style);
			sent += n;
			if (next_col != 0 || next_row != 0) begin
				cap = settled_width();
				if ($urandom_range(0, 1) == 1 && cap >= sobel_pkg::MIN_DIM)
					write_reg(sobel_pkg::REG_IMAGE_WIDTH,
						$urandom_range(0, (cap > 16) ? 16 : cap));
				else
					write_reg(sobel_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 10));
			end
		end
		if (next_col != 0 || next_row != 0)
			send_run(pixels_left(), STYLE_NOISE);
	endtask

	// oversized width keeps the first row going, then a narrow width closes the frame
	task automatic test_widest_rows();
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 'h1FFF);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 0);
		send_run(12, STYLE_NOISE);
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 5);
		send_run(pixels_left(), STYLE_NOISE);
	endtask

	// oversized height gives no frame end for several rows, then a short height closes it
	task automatic test_tallest_frame();
		write_reg(sobel_pkg::REG_IMAGE_WIDTH, 3);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 'h1FFF);
		send_run(3 * 8, STYLE_SMOOTH);
		write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 0);
		send_run(pixels_left(), STYLE_SMOOTH);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_pattern_frames();
		test_dimension_clamps();
		test_mid_frame_changes();
		test_random_frames(150);

		src_idle_pct = 85;
		sink_idle_pct = 26;
		test_random_frames(220);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_frames(220);
		test_widest_rows();
		test_tallest_frame();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/sobel_pkg.sv
rtl/sobel_queue.sv
rtl/sobel_front.sv
rtl/sobel_back.sv
rtl/sobel_edge_magnitude_core.sv
verif/sobel_edge_magnitude_core_test.sv
